/* rtl/stt_pkg.sv */
// shared types, character constants and helpers for the scene text tokenizer
`default_nettype none
package stt_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_STRING  = 3'd2,
		MODE_ESCAPE  = 3'd3,
		MODE_BARE    = 3'd4
	} mode_t;

	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_STREAM = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	localparam logic [1:0] ERR_NEWLINE = 2'd0;
	localparam logic [1:0] ERR_ESCAPE  = 2'd1;
	localparam logic [1:0] ERR_UNTERM  = 2'd2;
	localparam logic [1:0] ERR_NONE    = 2'd0;

	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam int MaxResults = 3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] token_byte;
		logic [1:0] error_code;
	} result_t;

	// results caused by one input word, entry 0 goes out first
	typedef struct packed {
		result_t [MaxResults-1:0] res;
		logic [1:0]               cnt;
	} bundle_t;

	function automatic result_t mk_result(input logic [1:0] kind, input logic [7:0] tb,
			input logic [1:0] err);
		result_t r;
		r.kind       = kind;
		r.token_byte = tb;
		r.error_code = err;
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	// msb set when the escape is legal, low byte is the translated character
	function automatic logic [8:0] esc_xlate(input logic [7:0] c);
		logic [8:0] r;
		case (c)
			8'h62:     r = {1'b1, 8'h08};
			8'h66:     r = {1'b1, 8'h0C};
			8'h6E:     r = {1'b1, 8'h0A};
			8'h72:     r = {1'b1, 8'h0D};
			8'h74:     r = {1'b1, 8'h09};
			CH_BSLASH: r = {1'b1, CH_BSLASH};
			CH_SQUOTE: r = {1'b1, CH_SQUOTE};
			CH_DQUOTE: r = {1'b1, CH_DQUOTE};
			default:   r = 9'h000;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/stt_decode.sv */
// per-byte lexer decode: next mode and the results of one input word
`default_nettype none
module stt_decode
	import stt_pkg::*;
(
	input  mode_t      mode,
	input  logic [7:0] in_byte,
	input  logic       stream_end,
	output mode_t      next_mode,
	output bundle_t    bnd
);

	logic [1:0] n;
	logic       do_idle;
	logic [8:0] esc;

	always_comb begin
		bnd       = '0;
		n         = 2'd0;
		next_mode = mode;
		do_idle   = 1'b0;
		esc       = esc_xlate(in_byte);
		if (stream_end) begin
			if (mode == MODE_BARE) begin
				bnd.res[n] = mk_result(KIND_END, 8'h00, ERR_NONE);
				n = n + 2'd1;
			end else if (mode == MODE_STRING || mode == MODE_ESCAPE) begin
				bnd.res[n] = mk_result(KIND_ERROR, 8'h00, ERR_UNTERM);
				n = n + 2'd1;
			end
			bnd.res[n] = mk_result(KIND_STREAM, 8'h00, ERR_NONE);
			n = n + 2'd1;
			next_mode = MODE_IDLE;
		end else begin
			case (mode)
				MODE_COMMENT: begin
					if (in_byte == CH_LF || in_byte == CH_CR)
						next_mode = MODE_IDLE;
				end
				MODE_STRING: begin
					if (in_byte == CH_LF) begin
						bnd.res[n] = mk_result(KIND_ERROR, 8'h00, ERR_NEWLINE);
						n = n + 2'd1;
						next_mode = MODE_IDLE;
					end else if (in_byte == CH_BSLASH) begin
						next_mode = MODE_ESCAPE;
					end else if (in_byte == CH_DQUOTE) begin
						bnd.res[n] = mk_result(KIND_BYTE, in_byte, ERR_NONE);
						n = n + 2'd1;
						bnd.res[n] = mk_result(KIND_END, 8'h00, ERR_NONE);
						n = n + 2'd1;
						next_mode = MODE_IDLE;
					end else begin
						bnd.res[n] = mk_result(KIND_BYTE, in_byte, ERR_NONE);
						n = n + 2'd1;
					end
				end
				MODE_ESCAPE: begin
					if (in_byte == CH_LF) begin
						bnd.res[n] = mk_result(KIND_ERROR, 8'h00, ERR_NEWLINE);
						n = n + 2'd1;
						next_mode = MODE_IDLE;
					end else if (esc[8]) begin
						bnd.res[n] = mk_result(KIND_BYTE, esc[7:0], ERR_NONE);
						n = n + 2'd1;
						next_mode = MODE_STRING;
					end else begin
						bnd.res[n] = mk_result(KIND_ERROR, 8'h00, ERR_ESCAPE);
						n = n + 2'd1;
						next_mode = MODE_IDLE;
					end
				end
				MODE_BARE: begin
					if (is_ws(in_byte) || in_byte == CH_DQUOTE ||
							in_byte == CH_LBRACK || in_byte == CH_RBRACK) begin
						bnd.res[n] = mk_result(KIND_END, 8'h00, ERR_NONE);
						n = n + 2'd1;
						do_idle = 1'b1;
					end else begin
						bnd.res[n] = mk_result(KIND_BYTE, in_byte, ERR_NONE);
						n = n + 2'd1;
					end
				end
				default: begin
					do_idle = 1'b1;
				end
			endcase
			// byte seen between tokens, also the byte that closed a bare token
			if (do_idle) begin
				next_mode = MODE_IDLE;
				if (is_ws(in_byte)) begin
					next_mode = MODE_IDLE;
				end else if (in_byte == CH_HASH) begin
					next_mode = MODE_COMMENT;
				end else begin
					bnd.res[n] = mk_result(KIND_BYTE, in_byte, ERR_NONE);
					n = n + 2'd1;
					if (in_byte == CH_DQUOTE) begin
						next_mode = MODE_STRING;
					end else if (in_byte == CH_LBRACK || in_byte == CH_RBRACK) begin
						bnd.res[n] = mk_result(KIND_END, 8'h00, ERR_NONE);
						n = n + 2'd1;
						next_mode = MODE_IDLE;
					end else begin
						next_mode = MODE_BARE;
					end
				end
			end
		end
		bnd.cnt = n;
	end

endmodule
`default_nettype wire

/* rtl/stt_outq.sv */
// result register: holds the results of one word and hands them out one per cycle while out_stall is low
`default_nettype none
module stt_outq
	import stt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  bundle_t    bnd,
	output logic       free,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] token_byte,
	output logic [1:0] error_code,
	output logic       last
);

	result_t [MaxResults-1:0] res_q;
	logic [1:0]               cnt_q;
	logic                     take;

	assign out_valid  = (cnt_q != 2'd0);
	assign take       = out_valid && !out_stall;
	assign free       = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall);
	assign kind       = res_q[0].kind;
	assign token_byte = res_q[0].token_byte;
	assign error_code = res_q[0].error_code;
	assign last       = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bnd.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bnd.res;
		end else if (take) begin
			for (int i = 0; i < MaxResults - 1; i++)
				res_q[i] <= res_q[i+1];
		end
	end

endmodule
`default_nettype wire

/* rtl/scene_text_tokenizer_top.sv */
// top level of the scene text tokenizer: input register, lexer mode, result queue
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall  | in_byte[7:0], stream_end
//  out     | out_valid / out_stall| kind[1:0], token_byte[7:0], error_code[1:0], last
//
// one word per cycle while each word gives at most one result and out_stall is low;
// a word giving more results holds back the next until its last result is leaving,
// set by the single result register port; words pass the input and result registers
// reset clears the input valid bit, the result count and the lexer mode (idle)
// out_stall backs up through the result queue into in_stall in the same cycle
// words that produce nothing are consumed even while earlier results wait
`default_nettype none
module scene_text_tokenizer_top
	import stt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       stream_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] token_byte,
	output logic [1:0] error_code,
	output logic       last
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// lexer state
	mode_t      mode_q;
	mode_t      next_mode;

	bundle_t    bnd;
	logic       q_free;
	logic       consume;
	logic       load;

	// a word leaves the input register when it makes nothing or the queue frees up
	assign consume  = valid_s1 && ((bnd.cnt == 2'd0) || q_free);
	assign load     = consume && (bnd.cnt != 2'd0);
	assign in_stall = valid_s1 && !consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			end_s1  <= stream_end;
		end
	end

	// mode advances once per consumed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else if (consume) begin
			mode_q <= next_mode;
		end
	end

	stt_decode u_decode (
		.mode       (mode_q),
		.in_byte    (byte_s1),
		.stream_end (end_s1),
		.next_mode  (next_mode),
		.bnd        (bnd)
	);

	stt_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.bnd        (bnd),
		.free       (q_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.kind       (kind),
		.token_byte (token_byte),
		.error_code (error_code),
		.last       (last)
	);

	// results only overwrite the queue once its last result is leaving
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!out_valid || (last && !out_stall)))
		else $error("result queue overwritten before drained");

	// every stream end returns the lexer to idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(consume && end_s1) |=> (mode_q == MODE_IDLE))
		else $error("lexer not idle after stream end");

	// input is only held back by a waiting word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && (out_stall || !last)))
		else $error("input stalled without a waiting word");

endmodule
`default_nettype wire
